@@ rtl/lfu_pkg.sv @@
package lfu_pkg;

  // Build-time defaults for the top level parameters
  localparam int unsigned ENTRIES_DEF  = 16;
  localparam int unsigned KEY_BITS_DEF = 32;

  // Counter, use count and stamp width
  localparam int unsigned CNT32_W = 32;

  // Configuration port
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;
  localparam int unsigned CAP_W      = 5;

  localparam logic [REG_IDX_W-1:0] REG_CAPACITY = REG_IDX_W'(0);
  localparam logic [CAP_W-1:0]     CAP_RESET    = CAP_W'(16);

  // Saturating increment on a 32-bit count
  function automatic logic [CNT32_W-1:0] sat_inc32(input logic [CNT32_W-1:0] v);
    logic [CNT32_W-1:0] r;
    r = (v == '1) ? v : v + CNT32_W'(1);
    return r;
  endfunction

endpackage

@@ rtl/lfu_cache_replacement_core.sv @@
// Channel   Direction  Handshake               Payload
// --------  ---------  ----------------------  ---------------------------------------
// in        sink       in_valid_i / in_stall_o  key_i
// out       source     out_valid_o / out_stall_i hit_o, evicted_o, victim_key_o, hit_total_o
// config    APB slave  psel/penable/pwrite      paddr, pwdata, prdata (capacity at 0x0)
//
// Each item is scanned over the resident entries, one read a cycle through the single
// read port; then the last entry comes back from the registered read, the scan closes
// and the write-back follows.
// Reset clears the resident count, the request and hit counters and the capacity (16);
// the directory memory itself is not cleared since only slots below the count are read.
// A stalled result sits in the output register; the next item is still accepted and
// scanned, and only its write-back waits for the output register to drain.
module lfu_cache_replacement_core #(
  parameter int unsigned ENTRIES  = lfu_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BITS = lfu_pkg::KEY_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [KEY_BITS-1:0]            key_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           hit_o,
  output logic                           evicted_o,
  output logic [KEY_BITS-1:0]            victim_key_o,
  output logic [lfu_pkg::CNT32_W-1:0]    hit_total_o,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lfu_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lfu_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lfu_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  import lfu_pkg::*;

  // Directory word: key, use count, insertion stamp
  localparam int unsigned WORD_W = KEY_BITS + 2 * CNT32_W;
  localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);

  localparam logic [CNT_W-1:0]   FILL_MAX   = CNT_W'(ENTRIES);
  localparam logic [CNT32_W-1:0] ENTRIES_32 = CNT32_W'(ENTRIES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_e;

  state_e               state_q, state_d;

  // Configuration
  logic [CAP_W-1:0]     cap_q, cap_d;
  logic [CNT32_W-1:0]   eff_cap;
  logic                 cfg_write;

  // Persistent counters
  logic [CNT_W-1:0]     fill_q, fill_d;
  logic [CNT32_W-1:0]   req_q, req_d;
  logic [CNT32_W-1:0]   hits_q, hits_d;

  // Item being worked on
  logic [KEY_BITS-1:0]  key_q, key_d;
  logic [CNT_W-1:0]     rd_idx_q, rd_idx_d;
  logic                 rvalid_q, rvalid_d;
  logic [IDX_W-1:0]     rsp_idx_q, rsp_idx_d;

  // Hit tracking
  logic                 found_q, found_d;
  logic [IDX_W-1:0]     found_idx_q, found_idx_d;
  logic [CNT32_W-1:0]   found_uses_q, found_uses_d;
  logic [CNT32_W-1:0]   found_stamp_q, found_stamp_d;

  // Victim tracking: least uses, then earliest stamp, then lowest slot
  logic                 have_vic_q, have_vic_d;
  logic [IDX_W-1:0]     vic_idx_q, vic_idx_d;
  logic [CNT32_W-1:0]   vic_uses_q, vic_uses_d;
  logic [CNT32_W-1:0]   vic_stamp_q, vic_stamp_d;
  logic [KEY_BITS-1:0]  vic_key_q, vic_key_d;

  // Output register
  logic                 out_valid_q, out_valid_d;
  logic                 hit_q, hit_d;
  logic                 evicted_q, evicted_d;
  logic [KEY_BITS-1:0]  victim_q, victim_d;
  logic [CNT32_W-1:0]   hit_total_q, hit_total_d;

  // Memory port
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [WORD_W-1:0]    mem_wdata;
  logic                 mem_re;
  logic [WORD_W-1:0]    mem_rdata;

  logic [KEY_BITS-1:0]  rd_key;
  logic [CNT32_W-1:0]   rd_uses;
  logic [CNT32_W-1:0]   rd_stamp;
  logic                 rd_better;
  logic                 cache_full;
  logic                 commit;

  lfu_mem #(
    .DEPTH  (ENTRIES),
    .WIDTH  (WORD_W),
    .ADDR_W (IDX_W)
  ) u_dir (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (mem_rdata)
  );

  // ---------------------------------------------------------------------------
  // Configuration port: zero-wait writes, reads of the capacity register
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready
                     && (paddr[APB_ADDR_W-1:2] == REG_CAPACITY);
  assign cap_d     = cfg_write ? pwdata[CAP_W-1:0] : cap_q;
  assign prdata    = (paddr[APB_ADDR_W-1:2] == REG_CAPACITY) ? APB_DATA_W'(cap_q) : '0;

  // Clamp the capacity into 1 .. ENTRIES
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CNT32_W'(1);
    end else if (CNT32_W'(cap_q) > ENTRIES_32) begin
      eff_cap = ENTRIES_32;
    end else begin
      eff_cap = CNT32_W'(cap_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Scan datapath
  // ---------------------------------------------------------------------------
  assign rd_key   = mem_rdata[WORD_W-1 -: KEY_BITS];
  assign rd_uses  = mem_rdata[2*CNT32_W-1 -: CNT32_W];
  assign rd_stamp = mem_rdata[CNT32_W-1:0];

  // Strictly better only, so the lowest slot keeps a full tie
  assign rd_better = !have_vic_q || (rd_uses < vic_uses_q)
                     || ((rd_uses == vic_uses_q) && (rd_stamp < vic_stamp_q));

  assign cache_full = CNT32_W'(fill_q) >= eff_cap;
  assign commit     = (state_q == ST_WRITE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d       = state_q;
    fill_d        = fill_q;
    req_d         = req_q;
    hits_d        = hits_q;
    key_d         = key_q;
    rd_idx_d      = rd_idx_q;
    rvalid_d      = 1'b0;
    rsp_idx_d     = rsp_idx_q;
    found_d       = found_q;
    found_idx_d   = found_idx_q;
    found_uses_d  = found_uses_q;
    found_stamp_d = found_stamp_q;
    have_vic_d    = have_vic_q;
    vic_idx_d     = vic_idx_q;
    vic_uses_d    = vic_uses_q;
    vic_stamp_d   = vic_stamp_q;
    vic_key_d     = vic_key_q;
    out_valid_d   = out_valid_q;
    hit_d         = hit_q;
    evicted_d     = evicted_q;
    victim_d      = victim_q;
    hit_total_d   = hit_total_q;
    mem_we        = 1'b0;
    mem_waddr     = found_idx_q;
    mem_wdata     = '0;
    mem_re        = 1'b0;

    // drain the output register
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          key_d      = key_i;
          req_d      = sat_inc32(req_q);
          rd_idx_d   = '0;
          found_d    = 1'b0;
          have_vic_d = 1'b0;
          state_d    = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // issue one read per cycle over the resident slots
        if (rd_idx_q < fill_q) begin
          mem_re    = 1'b1;
          rsp_idx_d = rd_idx_q[IDX_W-1:0];
          rd_idx_d  = rd_idx_q + CNT_W'(1);
          rvalid_d  = 1'b1;
        end
        // fold in the entry that came back
        if (rvalid_q) begin
          if (!found_q && (rd_key == key_q)) begin
            found_d       = 1'b1;
            found_idx_d   = rsp_idx_q;
            found_uses_d  = rd_uses;
            found_stamp_d = rd_stamp;
          end
          if (rd_better) begin
            have_vic_d  = 1'b1;
            vic_idx_d   = rsp_idx_q;
            vic_uses_d  = rd_uses;
            vic_stamp_d = rd_stamp;
            vic_key_d   = rd_key;
          end
        end
        if ((rd_idx_q == fill_q) && !rvalid_q) begin
          state_d = ST_WRITE;
        end
      end

      ST_WRITE: begin
        if (commit) begin
          out_valid_d = 1'b1;
          hit_d       = 1'b0;
          evicted_d   = 1'b0;
          victim_d    = '0;
          if (found_q) begin
            // bump the use count, keep the stamp
            mem_we      = 1'b1;
            mem_waddr   = found_idx_q;
            mem_wdata   = {key_q, sat_inc32(found_uses_q), found_stamp_q};
            hits_d      = sat_inc32(hits_q);
            hit_d       = 1'b1;
          end else if (cache_full && have_vic_q) begin
            // replace the victim in place
            mem_we      = 1'b1;
            mem_waddr   = vic_idx_q;
            mem_wdata   = {key_q, CNT32_W'(1), req_q};
            evicted_d   = 1'b1;
            victim_d    = vic_key_q;
          end else if (fill_q < FILL_MAX) begin
            // take the lowest free slot
            mem_we      = 1'b1;
            mem_waddr   = fill_q[IDX_W-1:0];
            mem_wdata   = {key_q, CNT32_W'(1), req_q};
            fill_d      = fill_q + CNT_W'(1);
          end
          hit_total_d = found_q ? sat_inc32(hits_q) : hits_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CAP_RESET;
      fill_q      <= '0;
      req_q       <= '0;
      hits_q      <= '0;
      rd_idx_q    <= '0;
      rvalid_q    <= 1'b0;
      found_q     <= 1'b0;
      have_vic_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      fill_q      <= fill_d;
      req_q       <= req_d;
      hits_q      <= hits_d;
      rd_idx_q    <= rd_idx_d;
      rvalid_q    <= rvalid_d;
      found_q     <= found_d;
      have_vic_q  <= have_vic_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    key_q         <= key_d;
    rsp_idx_q     <= rsp_idx_d;
    found_idx_q   <= found_idx_d;
    found_uses_q  <= found_uses_d;
    found_stamp_q <= found_stamp_d;
    vic_idx_q     <= vic_idx_d;
    vic_uses_q    <= vic_uses_d;
    vic_stamp_q   <= vic_stamp_d;
    vic_key_q     <= vic_key_d;
    hit_q         <= hit_d;
    evicted_q     <= evicted_d;
    victim_q      <= victim_d;
    hit_total_q   <= hit_total_d;
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign evicted_o    = evicted_q;
  assign victim_key_o = victim_q;
  assign hit_total_o  = hit_total_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_MAX)
    else $error("resident count beyond directory size");

  a_result_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_WRITE))
    else $error("result appeared without a write-back");

  a_hit_excl_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(hit_q && evicted_q))
    else $error("hit and eviction reported together");

  a_evict_needs_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && !found_q && cache_full) |-> have_vic_q)
    else $error("full directory without a victim");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (rd_idx_q <= fill_q))
    else $error("scan read beyond resident slots");

endmodule

@@ rtl/lfu_mem.sv @@
module lfu_mem #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned WIDTH  = 96,
  parameter int unsigned ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
